[sv/rau_pkg.sv]
package rau_pkg;

   localparam int WIDTH     = 16;
   localparam int KIND_W    = 3;
   localparam int PROD_W    = 2 * WIDTH;
   localparam int MAG_W     = PROD_W + 1;
   localparam int NUM_W     = 33;
   localparam int DEN_W     = 32;
   localparam int K_W       = 6;
   localparam int GCD_STEPS = 2 * MAG_W;
   localparam int DIV_STEPS = MAG_W;

   localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;

   typedef struct packed {
      logic             status;
      logic             is_equal;
      logic             reduce;
      logic             nneg;
      logic             dneg;
      logic [MAG_W-1:0] nmag;
      logic [MAG_W-1:0] dmag;
      logic [MAG_W-1:0] u;
      logic [MAG_W-1:0] v;
      logic [K_W-1:0]   k;
   } gcd_type;

   typedef struct packed {
      logic             status;
      logic             is_equal;
      logic             reduce;
      logic             nneg;
      logic             dneg;
      logic [MAG_W-1:0] g;
      logic [MAG_W:0]   nrem;
      logic [MAG_W-1:0] nq;
      logic [MAG_W:0]   drem;
      logic [MAG_W-1:0] dq;
   } div_type;

endpackage

[sv/rau_if.sv]
interface rau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [rau_pkg::KIND_W-1:0]    kind;
   logic signed [rau_pkg::WIDTH-1:0]     a_num;
   logic signed [rau_pkg::WIDTH-1:0]     a_den;
   logic signed [rau_pkg::WIDTH-1:0]     b_num;
   logic signed [rau_pkg::WIDTH-1:0]     b_den;

   modport source(output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rau_pkg::NUM_W-1:0]     res_num;
   logic signed [rau_pkg::DEN_W-1:0]     res_den;
   logic                                 is_equal;
   logic                                 status;

   modport source(output valid, res_num, res_den, is_equal, status, input ready);
   modport sink(input valid, res_num, res_den, is_equal, status, output ready);
endinterface

[sv/rational_arithmetic_unit.sv]
// Rational arithmetic unit.
// req_ch carries one item: an operation code and two signed fractions.
// rsp_ch returns one result per item: the fraction reduced to lowest terms
// (signs kept as computed; zero for compare and error), an equality flag
// for compare, and a status bit set when an input denominator, or the
// divisor's numerator in a divide, is zero. Unused codes give all zeros.
// The datapath is a fixed pipeline: one stage of products, one stage that
// forms the signed numerator and denominator, 66 binary gcd stages, one
// stage that rebuilds the gcd, 33 restoring division stages and an output
// register. A new item is accepted every cycle while rsp_ch is not stalled,
// so the gcd stages set latency, not throughput.
// The whole pipeline advances when the output register is empty or taken;
// while rsp_ch is stalled with a result waiting, req_ch.ready is low and
// every stage holds. Reset (synchronous) clears all valid bits, so the
// pipeline comes up empty; no item in flight survives it.
module rational_arithmetic_unit (
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);

   localparam int P = rau_pkg::PROD_W;
   localparam int M = rau_pkg::MAG_W;

   typedef struct packed {
      logic [rau_pkg::KIND_W-1:0] kind;
      logic                       err;
      logic                       bad;
      logic signed [P-1:0]        m1;
      logic signed [P-1:0]        m2;
      logic signed [P-1:0]        m3;
   } prod_type;

   logic             en;
   logic             p_vld_ff;
   prod_type         p_in;
   prod_type         p_ff;
   logic             c_vld_ff;
   rau_pkg::gcd_type c_in;
   rau_pkg::gcd_type c_ff;
   logic             gcd_vld;
   rau_pkg::gcd_type gcd_data;
   logic             div_vld;
   rau_pkg::div_type div_data;

   logic                             rsp_vld_ff;
   logic signed [rau_pkg::NUM_W-1:0] res_num_ff, res_num_in;
   logic signed [rau_pkg::DEN_W-1:0] res_den_ff, res_den_in;
   logic                             is_equal_ff;
   logic                             status_ff;

   logic signed [P+1:0] addend;
   logic signed [P+1:0] sum;
   logic signed [M-1:0] den_x;

   assign en           = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      p_in.kind = req_ch.kind;
      p_in.err  = (req_ch.a_den == '0) || (req_ch.b_den == '0) ||
                  ((req_ch.kind == rau_pkg::KIND_DIV) && (req_ch.b_num == '0));
      p_in.bad  = req_ch.kind > rau_pkg::KIND_CMP;
      p_in.m2   = P'(req_ch.b_num) * P'(req_ch.a_den);
      if (req_ch.kind == rau_pkg::KIND_MUL) begin
         p_in.m1 = P'(req_ch.a_num) * P'(req_ch.b_num);
      end else begin
         p_in.m1 = P'(req_ch.a_num) * P'(req_ch.b_den);
      end
      if (req_ch.kind == rau_pkg::KIND_DIV) begin
         p_in.m3 = P'(req_ch.a_den) * P'(req_ch.b_num);
      end else begin
         p_in.m3 = P'(req_ch.a_den) * P'(req_ch.b_den);
      end
   end

   always_comb begin
      case (p_ff.kind)
         rau_pkg::KIND_ADD: addend = {{2{p_ff.m2[P-1]}}, p_ff.m2};
         rau_pkg::KIND_SUB: addend = -{{2{p_ff.m2[P-1]}}, p_ff.m2};
         default:           addend = '0;
      endcase
      sum   = {{2{p_ff.m1[P-1]}}, p_ff.m1} + addend;
      den_x = {p_ff.m3[P-1], p_ff.m3};

      c_in.status   = !p_ff.bad && p_ff.err;
      c_in.is_equal = !p_ff.bad && !p_ff.err && (p_ff.kind == rau_pkg::KIND_CMP) &&
                      (p_ff.m1 == p_ff.m2);
      c_in.reduce   = !p_ff.bad && !p_ff.err && (p_ff.kind != rau_pkg::KIND_CMP);
      c_in.nneg     = sum[P+1];
      c_in.dneg     = den_x[M-1];
      c_in.nmag     = sum[P+1] ? M'(-sum) : M'(sum);
      c_in.dmag     = den_x[M-1] ? -den_x : den_x;
      c_in.u        = c_in.nmag;
      c_in.v        = c_in.dmag;
      c_in.k        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= req_ch.valid;
         c_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         c_ff <= c_in;
      end
   end

   rau_gcd u_gcd (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (c_vld_ff),
      .in_data  (c_ff),
      .out_vld  (gcd_vld),
      .out_data (gcd_data)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (gcd_vld),
      .in_data  (gcd_data),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   always_comb begin
      if (div_data.reduce) begin
         res_num_in = div_data.nneg ? -div_data.nq : div_data.nq;
         res_den_in = div_data.dneg ? -div_data.dq[rau_pkg::DEN_W-1:0]
                                    : div_data.dq[rau_pkg::DEN_W-1:0];
      end else begin
         res_num_in = '0;
         res_den_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_num_ff  <= res_num_in;
         res_den_ff  <= res_den_in;
         is_equal_ff <= div_data.is_equal;
         status_ff   <= div_data.status;
      end
   end

   assign rsp_ch.valid    = rsp_vld_ff;
   assign rsp_ch.res_num  = res_num_ff;
   assign rsp_ch.res_den  = res_den_ff;
   assign rsp_ch.is_equal = is_equal_ff;
   assign rsp_ch.status   = status_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status |->
         rsp_ch.res_num == '0 && rsp_ch.res_den == '0 && !rsp_ch.is_equal)
      else $error("error result carries a nonzero fraction");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_equal |-> rsp_ch.res_num == '0 && rsp_ch.res_den == '0)
      else $error("compare result carries a nonzero fraction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(p_vld_ff) && $stable(c_vld_ff) && $stable(div_vld))
      else $error("pipeline moved during a stall");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.status && !rsp_ch.is_equal && rsp_ch.res_num != '0
         |-> rsp_ch.res_den != '0)
      else $error("reduced result with zero denominator");

endmodule

[sv/rau_gcd.sv]
module rau_gcd (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  rau_pkg::gcd_type in_data,
   output logic             out_vld,
   output rau_pkg::gcd_type out_data
);

   localparam int N = rau_pkg::GCD_STEPS;

   function automatic rau_pkg::gcd_type gcd_step(rau_pkg::gcd_type s);
      rau_pkg::gcd_type r;
      r = s;
      if (s.reduce && (s.u != '0) && (s.v != '0)) begin
         if (!s.u[0] && !s.v[0]) begin
            r.u = s.u >> 1;
            r.v = s.v >> 1;
            r.k = s.k + 1'b1;
         end else if (!s.u[0]) begin
            r.u = s.u >> 1;
         end else if (!s.v[0]) begin
            r.v = s.v >> 1;
         end else if (s.u >= s.v) begin
            r.u = (s.u - s.v) >> 1;
         end else begin
            r.v = (s.v - s.u) >> 1;
         end
      end
      return r;
   endfunction

   logic [N-1:0]     vld_ff;
   logic [N-1:0]     vld_in;
   rau_pkg::gcd_type st_ff [N];
   rau_pkg::gcd_type st_in [N];

   assign vld_in = {vld_ff[N-2:0], in_vld};

   for (genvar i = 0; i < N; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign st_in[i] = gcd_step(in_data);
      end else begin : g_next
         assign st_in[i] = gcd_step(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_data = st_ff[N-1];

endmodule

[sv/rau_div.sv]
module rau_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  rau_pkg::gcd_type in_data,
   output logic             out_vld,
   output rau_pkg::div_type out_data
);

   localparam int N = rau_pkg::DIV_STEPS;
   localparam int M = rau_pkg::MAG_W;

   function automatic rau_pkg::div_type div_step(rau_pkg::div_type s);
      rau_pkg::div_type r;
      logic [M:0]       nt;
      logic [M:0]       dt;
      r  = s;
      nt = {s.nrem[M-1:0], s.nq[M-1]};
      dt = {s.drem[M-1:0], s.dq[M-1]};
      r.nq = {s.nq[M-2:0], 1'b0};
      r.dq = {s.dq[M-2:0], 1'b0};
      if (nt >= {1'b0, s.g}) begin
         nt      = nt - {1'b0, s.g};
         r.nq[0] = 1'b1;
      end
      if (dt >= {1'b0, s.g}) begin
         dt      = dt - {1'b0, s.g};
         r.dq[0] = 1'b1;
      end
      r.nrem = nt;
      r.drem = dt;
      return r;
   endfunction

   rau_pkg::div_type g_in;
   rau_pkg::div_type g_ff;
   logic             g_vld_ff;
   logic [M-1:0]     base;

   logic [N-1:0]     vld_ff;
   logic [N-1:0]     vld_in;
   rau_pkg::div_type st_ff [N];
   rau_pkg::div_type st_in [N];

   always_comb begin
      base          = (in_data.u == '0) ? in_data.v : in_data.u;
      g_in.status   = in_data.status;
      g_in.is_equal = in_data.is_equal;
      g_in.reduce   = in_data.reduce;
      g_in.nneg     = in_data.nneg;
      g_in.dneg     = in_data.dneg;
      g_in.g        = base << in_data.k;
      g_in.nrem     = '0;
      g_in.nq       = in_data.nmag;
      g_in.drem     = '0;
      g_in.dq       = in_data.dmag;
   end

   assign vld_in = {vld_ff[N-2:0], g_vld_ff};

   for (genvar i = 0; i < N; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign st_in[i] = div_step(g_ff);
      end else begin : g_next
         assign st_in[i] = div_step(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
         vld_ff   <= '0;
      end else if (en) begin
         g_vld_ff <= in_vld;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff  <= g_in;
         st_ff <= st_in;
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_data = st_ff[N-1];

endmodule
